/* rtl/core/zogts_pkg.sv */
// ----------------------------------------------------------------------------
// zogts_pkg
// Shared types and constants of the z-order grid trajectory segmenter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zogts_pkg;

    localparam int TRAJ_W     = 20;
    localparam int LON_W      = 32;
    localparam int LAT_W      = 31;
    localparam int CELL_W     = 20;
    localparam int INV_W      = 32;
    localparam int AXIS_REG_W = 4;
    localparam int PROD_SHIFT = 24;

    localparam int IN_FIELDS_W = TRAJ_W + LON_W + LAT_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_LEFT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_TOP      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_CELL_SIZE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_BITS     = 3'd3;

    localparam logic [AXIS_REG_W-1:0] AXIS_BITS_RESET = 4'd10;

    typedef struct packed {
        logic signed [LON_W-1:0] grid_left;
        logic signed [LAT_W-1:0] grid_top;
        logic [INV_W-1:0]        inv_cell_size;
        logic [AXIS_REG_W-1:0]   axis_bits;
    } grid_cfg_t;

endpackage

`default_nettype wire

/* rtl/core/z_order_grid_trajectory_segmenter.sv */
// ----------------------------------------------------------------------------
// z_order_grid_trajectory_segmenter
// Maps trajectory points to Morton-ordered grid cells and emits the runs of
// consecutive points that stay in one cell.
// ----------------------------------------------------------------------------
// channel  dir  tdata (lsb first)                               tlast
// s_       in   traj_id[19:0] lon[31:0] lat[30:0] pad           last_point
// m_       out  cell_index run_traj start_index end_index       last_of_input
//               point_count pad
// cfg_     in   write-only: grid_left, grid_top, inv_cell_size, axis_bits
//
// one point per cycle while m_ accepts results and no second result waits
// a point that closes a run and also ends its trajectory gives two transfers
// and holds the input until the second result leaves
// aresetn clears all valid flags and the in-trajectory flag and loads register defaults
// backpressure on m_tready passes back through the mapping and input registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module z_order_grid_trajectory_segmenter
    import zogts_pkg::*;
#(
    parameter int MAX_AXIS_BITS    = 10,
    parameter int POINT_INDEX_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // traj_id, lon, lat, zero pad
    input  wire logic [IN_TDATA_W-1:0]       s_tdata,
    input  wire logic                        s_tlast,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // cell_index, run_traj, start_index, end_index, point_count, zero pad
    output logic [((CELL_W + TRAJ_W + 3*POINT_INDEX_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                             m_tlast,
    input  wire logic                        cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int P          = POINT_INDEX_BITS;
    localparam int OUT_W      = CELL_W + TRAJ_W + 3*P + 1;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    grid_cfg_t cfg_reg;

    logic              pt_valid;
    logic              pt_ready;
    logic [CELL_W-1:0] pt_cell;
    logic [TRAJ_W-1:0] pt_traj;
    logic              pt_last;

    logic [CELL_W-1:0] run_cell;
    logic [TRAJ_W-1:0] run_traj;
    logic [P-1:0]      run_start;
    logic [P-1:0]      run_end;
    logic [P:0]        run_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_left     <= '0;
            cfg_reg.grid_top      <= '0;
            cfg_reg.inv_cell_size <= '0;
            cfg_reg.axis_bits     <= AXIS_BITS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GRID_LEFT:     cfg_reg.grid_left     <= cfg_data[LON_W-1:0];
                CFG_GRID_TOP:      cfg_reg.grid_top      <= cfg_data[LAT_W-1:0];
                CFG_INV_CELL_SIZE: cfg_reg.inv_cell_size <= cfg_data[INV_W-1:0];
                CFG_AXIS_BITS:     cfg_reg.axis_bits     <= cfg_data[AXIS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    zogts_cell_map #(
        .MAX_AXIS_BITS (MAX_AXIS_BITS)
    ) u_cell_map (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_traj  (s_tdata[TRAJ_W-1:0]),
        .in_lon   (s_tdata[TRAJ_W+LON_W-1:TRAJ_W]),
        .in_lat   (s_tdata[IN_FIELDS_W-1:TRAJ_W+LON_W]),
        .in_last  (s_tlast),
        .pt_valid (pt_valid),
        .pt_ready (pt_ready),
        .pt_cell  (pt_cell),
        .pt_traj  (pt_traj),
        .pt_last  (pt_last)
    );

    zogts_run_tracker #(
        .POINT_INDEX_BITS (POINT_INDEX_BITS)
    ) u_run_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pt_valid  (pt_valid),
        .pt_ready  (pt_ready),
        .pt_cell   (pt_cell),
        .pt_traj   (pt_traj),
        .pt_last   (pt_last),
        .run_valid (m_tvalid),
        .run_ready (m_tready),
        .run_cell  (run_cell),
        .run_traj  (run_traj),
        .run_start (run_start),
        .run_end   (run_end),
        .run_count (run_count),
        .run_last  (m_tlast)
    );

    assign m_tdata = OUT_DATA_W'({run_count, run_end, run_start, run_traj, run_cell});

endmodule

`default_nettype wire

/* rtl/core/zogts_cell_map.sv */
// ----------------------------------------------------------------------------
// zogts_cell_map
// Input register and grid mapping: scales, clamps and interleaves the point
// coordinates into a Morton cell index, registered for the run tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zogts_cell_map
    import zogts_pkg::*;
#(
    parameter int MAX_AXIS_BITS = 10
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire grid_cfg_t                cfg,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [TRAJ_W-1:0]        in_traj,
    input  wire logic signed [LON_W-1:0]  in_lon,
    input  wire logic signed [LAT_W-1:0]  in_lat,
    input  wire logic                     in_last,
    output logic                          pt_valid,
    input  wire logic                     pt_ready,
    output logic [CELL_W-1:0]             pt_cell,
    output logic [TRAJ_W-1:0]             pt_traj,
    output logic                          pt_last
);

    localparam int Q_W = 2 * INV_W - PROD_SHIFT;

    logic                     a_valid_reg;
    logic [TRAJ_W-1:0]        a_traj_reg;
    logic signed [LON_W-1:0]  a_lon_reg;
    logic signed [LAT_W-1:0]  a_lat_reg;
    logic                     a_last_reg;

    logic                     b_valid_reg;
    logic [CELL_W-1:0]        b_cell_reg;
    logic [TRAJ_W-1:0]        b_traj_reg;
    logic                     b_last_reg;

    logic                     b_load;
    logic signed [LON_W:0]    col_diff;
    logic signed [LON_W-1:0]  row_diff;
    logic                     col_pos;
    logic                     row_pos;
    logic [2*INV_W-1:0]       col_prod;
    logic [2*INV_W-1:0]       row_prod;
    logic [Q_W-1:0]           col_q;
    logic [Q_W-1:0]           row_q;
    logic [4:0]               bits_eff;
    logic [MAX_AXIS_BITS:0]   maxc_wide;
    logic [MAX_AXIS_BITS-1:0] maxc;
    logic [MAX_AXIS_BITS-1:0] col;
    logic [MAX_AXIS_BITS-1:0] row;
    logic [2*MAX_AXIS_BITS-1:0] code;

    assign b_load   = !b_valid_reg || pt_ready;
    assign in_ready = !a_valid_reg || b_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (in_ready) begin
            a_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            a_traj_reg <= in_traj;
            a_lon_reg  <= in_lon;
            a_lat_reg  <= in_lat;
            a_last_reg <= in_last;
        end
    end

    // offsets from the grid edges
    assign col_diff = {a_lon_reg[LON_W-1], a_lon_reg} - {cfg.grid_left[LON_W-1], cfg.grid_left};
    assign row_diff = {cfg.grid_top[LAT_W-1], cfg.grid_top} - {a_lat_reg[LAT_W-1], a_lat_reg};
    assign col_pos  = !col_diff[LON_W] && (col_diff != '0);
    assign row_pos  = !row_diff[LON_W-1] && (row_diff != '0);

    assign col_prod = (2*INV_W)'(col_diff[LON_W-1:0]) * (2*INV_W)'(cfg.inv_cell_size);
    assign row_prod = (2*INV_W)'(row_diff[LON_W-2:0]) * (2*INV_W)'(cfg.inv_cell_size);
    assign col_q    = col_prod[2*INV_W-1:PROD_SHIFT];
    assign row_q    = row_prod[2*INV_W-1:PROD_SHIFT];

    assign bits_eff  = ({1'b0, cfg.axis_bits} > 5'(MAX_AXIS_BITS)) ? 5'(MAX_AXIS_BITS)
                                                                    : {1'b0, cfg.axis_bits};
    assign maxc_wide = ((MAX_AXIS_BITS+1)'(1) << bits_eff) - (MAX_AXIS_BITS+1)'(1);
    assign maxc      = maxc_wide[MAX_AXIS_BITS-1:0];

    always_comb begin
        if (!col_pos) begin
            col = '0;
        end else if (col_q > Q_W'(maxc)) begin
            col = maxc;
        end else begin
            col = col_q[MAX_AXIS_BITS-1:0];
        end
        if (!row_pos) begin
            row = '0;
        end else if (row_q > Q_W'(maxc)) begin
            row = maxc;
        end else begin
            row = row_q[MAX_AXIS_BITS-1:0];
        end
    end

    // col in the even bits, row in the odd bits
    always_comb begin
        code = '0;
        for (int i = 0; i < MAX_AXIS_BITS; i++) begin
            code[2*i]   = col[i];
            code[2*i+1] = row[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_load) begin
            b_valid_reg <= a_valid_reg;
        end
        if (b_load && a_valid_reg) begin
            b_cell_reg <= CELL_W'(code);
            b_traj_reg <= a_traj_reg;
            b_last_reg <= a_last_reg;
        end
    end

    assign pt_valid = b_valid_reg;
    assign pt_cell  = b_cell_reg;
    assign pt_traj  = b_traj_reg;
    assign pt_last  = b_last_reg;

endmodule

`default_nettype wire

/* rtl/core/zogts_run_tracker.sv */
// ----------------------------------------------------------------------------
// zogts_run_tracker
// Run state per trajectory: detects cell changes and trajectory ends and
// issues finished runs through an output register and a second-run slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zogts_run_tracker
    import zogts_pkg::*;
#(
    parameter int POINT_INDEX_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        pt_valid,
    output logic                             pt_ready,
    input  wire logic [CELL_W-1:0]           pt_cell,
    input  wire logic [TRAJ_W-1:0]           pt_traj,
    input  wire logic                        pt_last,
    output logic                             run_valid,
    input  wire logic                        run_ready,
    output logic [CELL_W-1:0]                run_cell,
    output logic [TRAJ_W-1:0]                run_traj,
    output logic [POINT_INDEX_BITS-1:0]      run_start,
    output logic [POINT_INDEX_BITS-1:0]      run_end,
    output logic [POINT_INDEX_BITS:0]        run_count,
    output logic                             run_last
);

    localparam int P = POINT_INDEX_BITS;

    typedef struct packed {
        logic [CELL_W-1:0] cell_idx;
        logic [TRAJ_W-1:0] traj;
        logic [P-1:0]      start;
        logic [P-1:0]      stop;
        logic [P:0]        count;
        logic              last;
    } run_t;

    logic              in_traj_reg;
    logic [CELL_W-1:0] run_cell_reg;
    logic [P-1:0]      run_start_reg;
    logic [P-1:0]      point_cnt_reg;
    logic [TRAJ_W-1:0] run_owner_reg;

    logic              out_valid_reg;
    run_t              out_reg;
    logic              pend_valid_reg;
    run_t              pend_reg;

    logic              change;
    logic              out_free;
    logic              take;
    logic [P-1:0]      idx;
    logic [P-1:0]      prev_idx;
    logic [CELL_W-1:0] cell_next;
    logic [P-1:0]      start_next;
    logic [TRAJ_W-1:0] owner_next;
    run_t              change_run;
    run_t              final_run;
    run_t              first_run;

    assign change   = in_traj_reg && (pt_cell != run_cell_reg);
    assign out_free = !out_valid_reg || run_ready;
    assign pt_ready = !pend_valid_reg && (out_free || (!change && !pt_last));
    assign take     = pt_valid && pt_ready;

    assign idx        = in_traj_reg ? point_cnt_reg + P'(1) : '0;
    assign prev_idx   = idx - P'(1);
    assign cell_next  = (!in_traj_reg || change) ? pt_cell : run_cell_reg;
    assign start_next = !in_traj_reg ? '0 : (change ? idx : run_start_reg);
    assign owner_next = in_traj_reg ? run_owner_reg : pt_traj;

    always_comb begin
        change_run.cell_idx = run_cell_reg;
        change_run.traj     = run_owner_reg;
        change_run.start    = run_start_reg;
        change_run.stop     = prev_idx;
        change_run.count    = {1'b0, prev_idx - run_start_reg} + (P+1)'(1);
        change_run.last     = !pt_last;

        final_run.cell_idx  = cell_next;
        final_run.traj      = owner_next;
        final_run.start     = start_next;
        final_run.stop      = idx;
        final_run.count     = {1'b0, idx - start_next} + (P+1)'(1);
        final_run.last      = 1'b1;

        first_run = change ? change_run : final_run;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_traj_reg <= 1'b0;
        end else if (take) begin
            in_traj_reg <= !pt_last;
        end
        if (take) begin
            run_cell_reg  <= cell_next;
            run_start_reg <= start_next;
            point_cnt_reg <= idx;
            run_owner_reg <= owner_next;
        end
    end

    // second run of a point waits in the pending slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (pend_valid_reg) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (take && (change || pt_last)) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= change && pt_last;
            end else begin
                out_valid_reg  <= 1'b0;
            end
        end
        if (out_free) begin
            if (pend_valid_reg) begin
                out_reg <= pend_reg;
            end else if (take) begin
                out_reg  <= first_run;
                pend_reg <= final_run;
            end
        end
    end

    assign run_valid = out_valid_reg;
    assign run_cell  = out_reg.cell_idx;
    assign run_traj  = out_reg.traj;
    assign run_start = out_reg.start;
    assign run_end   = out_reg.stop;
    assign run_count = out_reg.count;
    assign run_last  = out_reg.last;

endmodule

`default_nettype wire
